/* rtl/i2cms_pkg.sv */
// Shared types and constants for the I2C master bit sequencer.
package i2cms_pkg;

   // Command codes carried in the op field
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4,
      OP_SACK  = 3'd5,
      OP_RACK  = 3'd6
   } op_type;

   localparam int REQ_W       = 16;   // op, write_byte, ack_level, sda_in, zero fill
   localparam int RSP_W       = 16;   // scl, sda, busy, done, read_byte, ack_seen, zero fill
   localparam int TICKS_W     = 16;
   localparam int STEP_W      = 5;
   localparam int BYTE_W      = 8;
   localparam int BIT_COUNT   = 8;
   localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(10);

   // Number of pin steps in each command sequence
   function automatic logic [STEP_W-1:0] step_total(input op_type cmd);
      logic [STEP_W-1:0] total;
      case (cmd)
         OP_START: total = STEP_W'(4);
         OP_STOP:  total = STEP_W'(3);
         OP_WRITE: total = STEP_W'(3 * BIT_COUNT);
         OP_READ:  total = STEP_W'(1 + 3 * BIT_COUNT);
         OP_SACK:  total = STEP_W'(3);
         OP_RACK:  total = STEP_W'(4);
         default:  total = '0;
      endcase
      return total;
   endfunction

endpackage

/* rtl/i2cms_out_fifo.sv */
// Two-entry result queue between the sequencer and the rsp channel.
module i2cms_out_fifo #(
   parameter int DATA_W = i2cms_pkg::RSP_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);
   logic [DATA_W-1:0] mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              pop;

   assign out_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/i2c_master_bit_sequencer_unit.sv */
// I2C master bit sequencer: top level with tick stage, pin sequencer and result queue.
//
// Usage: every transfer on the req channel is one time tick. It carries an
// optional command (start, stop, write byte, read byte, send ack, receive
// ack) and the sampled SDA level. Every accepted tick yields exactly one
// transfer on the rsp channel with the SCL/SDA drive levels, busy, a one-tick
// done pulse, the last read byte and the last sampled ack level.
// A command is taken only while idle; one arriving while busy is dropped.
// Each pin step is held for ticks_per_step ticks (0 acts as 1); it resets to 10.
// It must be written on the csr channel while no command runs; the block does not enforce this.
// A tick is registered in the input stage and its result is registered in the
// two-entry result queue before it shows on rsp. Throughput: one tick per cycle
// while the result queue has space, set by the state update between the input
// stage and the result queue.
// Reset: the line levels go released (1), the sequencer idles, the queue
// empties. When the rsp receiver stalls, the queue absorbs up to two results
// and the input stage holds one tick; req_tready then drops until space frees.
module i2c_master_bit_sequencer_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [2:0] op, [10:3] write_byte, [11] ack_level, [12] sda_in, [15:13] zero
   input  logic [i2cms_pkg::REQ_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res,
   // [11:4] read_byte, [12] ack_seen, [15:13] zero
   output logic [i2cms_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [i2cms_pkg::TICKS_W-1:0] csr_data
);
   import i2cms_pkg::*;

   // Input stage
   logic              in_valid_ff, in_valid_in;
   logic [REQ_W-1:0]  in_data_ff;
   logic              advance;
   logic              fifo_full;

   // Sequencer state
   logic [TICKS_W-1:0] tps_ff;
   op_type             command_ff, command_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [TICKS_W-1:0] tick_ff, tick_in;
   logic [1:0]         phase_ff, phase_in;
   logic [2:0]         bit_ff, bit_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               ack_ff, ack_in;
   logic [BYTE_W-1:0]  result_ff, result_in;

   // Decoded tick fields and step control
   op_type             op_f;
   logic [BYTE_W-1:0]  wbyte_f;
   logic               ackl_f;
   logic               sda_f;
   logic [TICKS_W-1:0] hold;
   logic [STEP_W-1:0]  step_next;
   logic               act_en;
   logic               done;
   logic               start_ok;
   logic [RSP_W-1:0]   result_word;

   assign op_f    = op_type'(in_data_ff[2:0]);
   assign wbyte_f = in_data_ff[10:3];
   assign ackl_f  = in_data_ff[11];
   assign sda_f   = in_data_ff[12];

   assign advance    = in_valid_ff && !fifo_full;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_data_ff <= req_tdata;
      end
   end

   // Step length register
   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TICKS_RESET;
      end else if (csr_valid && csr_ready) begin
         tps_ff <= csr_data;
      end
   end

   assign hold      = (tps_ff == '0) ? TICKS_W'(1) : tps_ff;
   assign step_next = step_ff + STEP_W'(1);

   // Next sequencer state for one tick
   always_comb begin
      command_in = command_ff;
      step_in    = step_ff;
      tick_in    = tick_ff;
      phase_in   = phase_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      ack_in     = ack_ff;
      result_in  = result_ff;
      act_en     = 1'b0;
      done       = 1'b0;
      start_ok   = 1'b0;

      if (command_ff == OP_NONE) begin
         // Idle: take a new command, valid codes only
         case (op_f)
            OP_START, OP_STOP, OP_WRITE, OP_READ, OP_SACK, OP_RACK: start_ok = 1'b1;
            default: start_ok = 1'b0;
         endcase
         if (start_ok) begin
            command_in = op_f;
            step_in    = '0;
            tick_in    = TICKS_W'(1);
            phase_in   = 2'd0;
            bit_in     = 3'd0;
            act_en     = 1'b1;
            if (op_f == OP_WRITE) begin
               shift_in = wbyte_f;
            end else if (op_f == OP_SACK) begin
               shift_in = {{(BYTE_W-1){1'b0}}, ackl_f};
            end
         end
      end else if (tick_ff >= hold) begin
         // Hold elapsed: next step or completion
         if (step_next >= step_total(command_ff)) begin
            if (command_ff == OP_READ) begin
               result_in = shift_ff;
            end
            command_in = OP_NONE;
            step_in    = '0;
            tick_in    = '0;
            done       = 1'b1;
         end else begin
            step_in = step_next;
            tick_in = TICKS_W'(1);
            act_en  = 1'b1;
            // Read has a lone release step before its bit triplets
            if (command_ff == OP_READ && step_ff == '0) begin
               phase_in = 2'd0;
            end else if (phase_ff == 2'd2) begin
               phase_in = 2'd0;
               bit_in   = bit_ff + 3'd1;
            end else begin
               phase_in = phase_ff + 2'd1;
            end
         end
      end else begin
         tick_in = tick_ff + TICKS_W'(1);
      end

      // Perform the pin step just entered
      if (act_en) begin
         case (command_in)
            OP_START: begin
               case (step_in)
                  STEP_W'(0): sda_in = 1'b1;
                  STEP_W'(1): scl_in = 1'b1;
                  STEP_W'(2): sda_in = 1'b0;
                  default:    scl_in = 1'b0;
               endcase
            end
            OP_STOP: begin
               case (step_in)
                  STEP_W'(0): sda_in = 1'b0;
                  STEP_W'(1): scl_in = 1'b1;
                  default:    sda_in = 1'b1;
               endcase
            end
            OP_WRITE: begin
               case (phase_in)
                  2'd0:    sda_in = shift_in[3'd7 - bit_in];
                  2'd1:    scl_in = 1'b1;
                  default: scl_in = 1'b0;
               endcase
            end
            OP_READ: begin
               if (step_in == '0) begin
                  sda_in   = 1'b1;
                  shift_in = '0;
               end else begin
                  case (phase_in)
                     2'd0:    scl_in = 1'b1;
                     2'd1:    shift_in = {shift_ff[BYTE_W-2:0], sda_f};
                     default: scl_in = 1'b0;
                  endcase
               end
            end
            OP_SACK: begin
               case (step_in)
                  STEP_W'(0): sda_in = shift_in[0];
                  STEP_W'(1): scl_in = 1'b1;
                  default:    scl_in = 1'b0;
               endcase
            end
            OP_RACK: begin
               case (step_in)
                  STEP_W'(0): sda_in = 1'b1;
                  STEP_W'(1): scl_in = 1'b1;
                  STEP_W'(2): ack_in = sda_f;
                  default:    scl_in = 1'b0;
               endcase
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff <= OP_NONE;
         step_ff    <= '0;
         tick_ff    <= '0;
         phase_ff   <= 2'd0;
         bit_ff     <= 3'd0;
         shift_ff   <= '0;
         scl_ff     <= 1'b1;
         sda_ff     <= 1'b1;
         ack_ff     <= 1'b1;
         result_ff  <= '0;
      end else if (advance) begin
         command_ff <= command_in;
         step_ff    <= step_in;
         tick_ff    <= tick_in;
         phase_ff   <= phase_in;
         bit_ff     <= bit_in;
         shift_ff   <= shift_in;
         scl_ff     <= scl_in;
         sda_ff     <= sda_in;
         ack_ff     <= ack_in;
         result_ff  <= result_in;
      end
   end

   // Result word, packed from the lowest bit up
   assign result_word = {3'b000, ack_in, result_in, done, (command_in != OP_NONE),
                         sda_in, scl_in};

   i2cms_out_fifo #(
      .DATA_W(RSP_W)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (result_word),
      .full      (fifo_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   // Idle sequencer keeps its step and tick counters cleared
   assert property (@(posedge clock) disable iff (reset)
      command_ff == OP_NONE |-> (step_ff == '0 && tick_ff == '0))
      else $error("idle sequencer with live counters");

   // A running command never sits past its last step
   assert property (@(posedge clock) disable iff (reset)
      command_ff != OP_NONE |-> step_ff < step_total(command_ff))
      else $error("step index past end of sequence");

   // Completion pulse only with the sequencer going idle
   assert property (@(posedge clock) disable iff (reset)
      advance && done |-> command_in == OP_NONE && command_ff != OP_NONE)
      else $error("done without a finishing command");

   // A tick is only pushed when it left the input stage
   assert property (@(posedge clock) disable iff (reset)
      advance |=> !in_valid_ff || $past(req_tvalid && req_tready))
      else $error("input stage kept a consumed tick");

endmodule
